/* rtl/fpa_pkg.sv */
// Package for the fixed-point ALU: operation codes, item and result types.
// Used by the front, back and top modules and the testbench; depends on nothing.
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int MID_DEPTH     = 4;
    localparam int OUT_DEPTH     = 2;
    localparam int DIV_STAGES    = 32;

    typedef enum logic [3:0] {
        KIND_ADD  = 4'd0,
        KIND_SUB  = 4'd1,
        KIND_MUL  = 4'd2,
        KIND_DIV  = 4'd3,
        KIND_MIN  = 4'd4,
        KIND_MAX  = 4'd5,
        KIND_INC  = 4'd6,
        KIND_DEC  = 4'd7,
        KIND_INT  = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        CLS_PASS = 2'd0,
        CLS_MUL  = 2'd1,
        CLS_DIV  = 2'd2
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [31:0] res;
        logic        less;
        logic        equal;
        logic        greater;
        logic        dz;
        logic        neg;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
    } fpa_item_t;

    typedef struct packed {
        logic [31:0] result;
        logic        less;
        logic        equal;
        logic        greater;
        logic        dz;
    } fpa_res_t;

endpackage

/* rtl/fpa_fifo.sv */
// Small first-in first-out queue with registered storage.
// Stand-alone; used between the front and back parts and at the result side.
module fpa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/fpa_front.sv */
// Front part: takes operations, compares operands, computes the kinds other than
// multiply and divide and prepares magnitudes for those two. Depends on fpa_pkg.
module fpa_front #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [3:0]          kind,
    input  logic signed [31:0]  operand_a,
    input  logic signed [31:0]  operand_b,
    output fpa_pkg::fpa_item_t  item,
    output logic                item_push,
    input  logic                item_full
);
    import fpa_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    fpa_item_t  item_reg;
    fpa_item_t  item_next;
    logic       accept;

    assign full      = valid_reg && item_full;
    assign accept    = push && !full;
    assign item_push = valid_reg;
    assign item      = item_reg;

    always_comb
    begin
        item_next         = '0;
        item_next.cls     = CLS_PASS;
        item_next.less    = (operand_a < operand_b);
        item_next.equal   = (operand_a == operand_b);
        item_next.greater = (operand_a > operand_b);
        item_next.neg     = operand_a[31] ^ operand_b[31];
        item_next.mag_a   = operand_a[31] ? 32'(-operand_a) : operand_a;
        item_next.mag_b   = operand_b[31] ? 32'(-operand_b) : operand_b;
        unique case (kind)
            KIND_ADD: item_next.res = operand_a + operand_b;
            KIND_SUB: item_next.res = operand_a - operand_b;
            KIND_MUL: item_next.cls = CLS_MUL;
            KIND_DIV:
            begin
                if (operand_b == 32'sd0)
                begin
                    item_next.dz = 1'b1;
                end
                else
                begin
                    item_next.cls = CLS_DIV;
                end
            end
            KIND_MIN: item_next.res = (operand_a < operand_b) ? operand_a : operand_b;
            KIND_MAX: item_next.res = (operand_a > operand_b) ? operand_a : operand_b;
            KIND_INC: item_next.res = operand_a + 32'sd1;
            KIND_DEC: item_next.res = operand_a - 32'sd1;
            KIND_INT: item_next.res = operand_a >>> FRAC_BITS;
            default:  item_next.res = '0;
        endcase
    end

    assign valid_next = accept || (valid_reg && item_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

/* rtl/fpa_back.sv */
// Back part: multiplier, one-bit-per-stage restoring divider, rounding and
// saturation, stalling as one pipeline. Depends on fpa_pkg.
module fpa_back #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fpa_pkg::fpa_item_t  item,
    input  logic                item_empty,
    output logic                item_pop,
    output fpa_pkg::fpa_res_t   res,
    output logic                res_push,
    input  logic                res_full
);
    import fpa_pkg::*;

    localparam int NS = DIV_STAGES;

    typedef struct packed {
        cls_t        cls;
        logic [31:0] res;
        logic        less;
        logic        equal;
        logic        greater;
        logic        dz;
        logic        neg;
        logic        ovf;
        logic [31:0] den;
        logic [31:0] rem;
        logic [31:0] lo;
        logic [31:0] quo;
        logic [31:0] mulq;
    } stage_t;

    function automatic logic [31:0] sat32(logic [32:0] m, logic ovf, logic neg);
        logic [32:0] nm;
        nm = ~m + 33'd1;
        if (neg)
        begin
            return (ovf || m >= 33'h080000000) ? 32'h80000000 : nm[31:0];
        end
        return (ovf || m > 33'h07FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
    endfunction

    stage_t      st_reg  [0:NS];
    stage_t      st_next [0:NS];
    logic [NS:0] vld_reg;
    logic [63:0] prod_reg;
    logic [63:0] prod_next;
    logic [63:0] num;
    logic [63:0] mul_rnd;
    logic        adv;
    logic [32:0] div_q;
    logic        div_rnd;
    logic [31:0] final_res;

    assign adv      = !vld_reg[NS] || !res_full;
    assign item_pop = adv && !item_empty;
    assign res_push = vld_reg[NS];

    assign num       = {32'd0, item.mag_a} << FRAC_BITS;
    assign prod_next = item.mag_a * item.mag_b;
    assign mul_rnd   = (prod_reg + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

    always_comb
    begin
        st_next[0]         = '0;
        st_next[0].cls     = item.cls;
        st_next[0].res     = item.res;
        st_next[0].less    = item.less;
        st_next[0].equal   = item.equal;
        st_next[0].greater = item.greater;
        st_next[0].dz      = item.dz;
        st_next[0].neg     = item.neg;
        st_next[0].den     = item.mag_b;
        st_next[0].rem     = num[63:32];
        st_next[0].lo      = num[31:0];
        st_next[0].ovf     = (num[63:32] >= item.mag_b);
    end

    for (genvar k = 1; k <= NS; k++)
    begin : g_stage
        logic [32:0] t;
        logic [32:0] d;
        logic        ge;
        always_comb
        begin
            t  = {st_reg[k-1].rem, st_reg[k-1].lo[31]};
            d  = t - {1'b0, st_reg[k-1].den};
            ge = (t >= {1'b0, st_reg[k-1].den});
            st_next[k]     = st_reg[k-1];
            st_next[k].rem = ge ? d[31:0] : t[31:0];
            st_next[k].lo  = {st_reg[k-1].lo[30:0], 1'b0};
            st_next[k].quo = {st_reg[k-1].quo[30:0], ge};
            if (k == 1)
            begin
                st_next[k].mulq = sat32(mul_rnd[32:0], |mul_rnd[63:33], st_reg[0].neg);
            end
        end
    end

    assign div_rnd = ({st_reg[NS].rem, 1'b0} >= {1'b0, st_reg[NS].den});
    assign div_q   = {1'b0, st_reg[NS].quo} + {32'd0, div_rnd};

    always_comb
    begin
        case (st_reg[NS].cls)
            CLS_MUL: final_res = st_reg[NS].mulq;
            CLS_DIV: final_res = sat32(div_q, st_reg[NS].ovf, st_reg[NS].neg);
            default: final_res = st_reg[NS].res;
        endcase
        res.result  = final_res;
        res.less    = st_reg[NS].less;
        res.equal   = st_reg[NS].equal;
        res.greater = st_reg[NS].greater;
        res.dz      = st_reg[NS].dz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-1:0], !item_empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            for (int i = 0; i <= NS; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS] |-> $onehot({res.less, res.equal, res.greater}))
        else $error("comparison flags not one-hot");
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NS] && res.dz) |-> (res.result == 32'd0))
        else $error("divide by zero result not zero");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NS] && !adv) |=> (vld_reg[NS] && $stable(res.result)))
        else $error("stalled result changed");
    a_pop_adv: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> adv)
        else $error("item taken while pipeline stalled");
`endif

endmodule

/* rtl/fixed_point_alu.sv */
// Path: an input transfer passes the front register, the front queue and 33 back
// stages (incl. the 32-step divider) before its result enters the output queue.
// Throughput: one operation per cycle while results are popped; the multiplier
// and each divider step are pipeline stages, so nothing iterates in place.
// Reset (rst_n, asynchronous, active low) empties all queues and stages.
// Depends on fpa_pkg, fpa_fifo, fpa_front and fpa_back.
module fixed_point_alu #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         kind,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] result_raw,
    output logic               a_less,
    output logic               a_equal,
    output logic               a_greater,
    output logic               div_zero
);
    import fpa_pkg::*;

    fpa_item_t front_item;
    fpa_item_t mid_item;
    logic      front_push;
    logic      mid_full;
    logic      mid_empty;
    logic      mid_pop;
    fpa_res_t  back_res;
    fpa_res_t  out_res;
    logic      back_push;
    logic      out_full;

    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .item      (front_item),
        .item_push (front_push),
        .item_full (mid_full)
    );

    fpa_fifo #(.WIDTH($bits(fpa_item_t)), .DEPTH(MID_DEPTH)) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_item),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_data (mid_item),
        .empty   (mid_empty)
    );

    fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (mid_item),
        .item_empty (mid_empty),
        .item_pop   (mid_pop),
        .res        (back_res),
        .res_push   (back_push),
        .res_full   (out_full)
    );

    fpa_fifo #(.WIDTH($bits(fpa_res_t)), .DEPTH(OUT_DEPTH)) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (back_push),
        .wr_data (back_res),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign result_raw = out_res.result;
    assign a_less     = out_res.less;
    assign a_equal    = out_res.equal;
    assign a_greater  = out_res.greater;
    assign div_zero   = out_res.dz;

endmodule

/* verif/tb_fixed_point_alu.sv */
// Self-checking testbench for the signed fixed-point ALU, queue handshake on both sides.
// Predicts each result in-line from the operands, with random idling and backpressure.
// Depends on fpa_pkg and fixed_point_alu.
module tb_fixed_point_alu;
    import fpa_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct {
        logic [3:0]  kind;
        logic [31:0] a;
        logic [31:0] b;
    } op_t;

    typedef struct {
        logic [31:0] result;
        logic        less;
        logic        equal;
        logic        greater;
        logic        dz;
    } alu_out_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [3:0]         kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic               empty;
    logic               pop;
    logic signed [31:0] result_raw;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               div_zero;

    op_t      pending_ops[$];
    alu_out_t awaited[$];
    int       errors;
    int       cycle_count;
    bit       sender_hold;
    bit       quiet_tail;
    bit       in_xfer;
    int       send_gap;
    int       recv_gap;
    int       recv_hold;

    fixed_point_alu DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .kind(kind),
        .operand_a(operand_a), .operand_b(operand_b), .empty(empty), .pop(pop),
        .result_raw(result_raw), .a_less(a_less), .a_equal(a_equal),
        .a_greater(a_greater), .div_zero(div_zero)
    );

    function automatic logic [31:0] saturate(logic [63:0] m, bit neg);
        if (neg)
            return (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-m);
        return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    endfunction

    function automatic alu_out_t alu_predict(op_t op);
        alu_out_t    r;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] rem;
        sa = op.a;
        sb = op.b;
        ma = sa < 0 ? 64'(-64'(sa)) : 64'(sa);
        mb = sb < 0 ? 64'(-64'(sb)) : 64'(sb);
        r.result = '0;
        r.dz = 1'b0;
        r.less = sa < sb;
        r.equal = sa == sb;
        r.greater = sa > sb;
        case (op.kind)
            KIND_ADD: r.result = op.a + op.b;
            KIND_SUB: r.result = op.a - op.b;
            KIND_MUL:
            begin
                q = (ma * mb + (64'd1 << (FB - 1))) >> FB;
                r.result = saturate(q, (sa < 0) != (sb < 0));
            end
            KIND_DIV:
            begin
                if (sb == 0)
                    r.dz = 1'b1;
                else
                begin
                    num = ma << FB;
                    q = num / mb;
                    rem = num % mb;
                    if (2 * rem >= mb)
                        q = q + 1;
                    r.result = saturate(q, (sa < 0) != (sb < 0));
                end
            end
            KIND_MIN: r.result = (sa < sb) ? op.a : op.b;
            KIND_MAX: r.result = (sa > sb) ? op.a : op.b;
            KIND_INC: r.result = op.a + 1;
            KIND_DEC: r.result = op.a - 1;
            KIND_INT: r.result = sa >>> FB;
            default: r.result = '0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 4096)) - 2048);
            2: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            4: return $urandom_range(0, 2) - 1;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic add_op(logic [3:0] k, logic [31:0] a, logic [31:0] b);
        op_t op;
        op.kind = k;
        op.a = a;
        op.b = b;
        pending_ops.push_back(op);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // The input transfer is decided at the rising edge, so it is recorded there.
    always @(posedge clk)
    begin
        in_xfer <= rst_n && push && !full;
    end

    // Driver: one transfer per accepted push; gaps come in bursts.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                void'(pending_ops.pop_front());
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                push <= 1'b0;
            end
            else if (sender_hold || pending_ops.size() == 0)
            begin
                push <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 19) == 0)
            begin
                send_gap <= $urandom_range(1, 17) - 1;
                push <= 1'b0;
            end
            else
            begin
                push <= 1'b1;
                kind <= pending_ops[0].kind;
                operand_a <= pending_ops[0].a;
                operand_b <= pending_ops[0].b;
            end
        end
    end

    // Receiver: pops with random stalls and one long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (recv_hold > 0)
        begin
            recv_hold <= recv_hold - 1;
            pop <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            pop <= 1'b0;
        end
        else if (!quiet_tail && $urandom_range(0, 14) == 0)
        begin
            recv_gap <= $urandom_range(1, 17) - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // Monitor: predictions are queued on input transfers, checked on output transfers.
    always @(posedge clk)
    begin
        alu_out_t want;
        op_t      op;
        if (rst_n && push && !full)
        begin
            op.kind = kind;
            op.a = operand_a;
            op.b = operand_b;
            awaited.push_back(alu_predict(op));
        end
        if (rst_n && pop && !empty)
        begin
            if (awaited.size() == 0)
            begin
                errors = errors + 1;
                $display("%0t: result %h with no transfer outstanding", $time, result_raw);
            end
            else
            begin
                want = awaited.pop_front();
                if (result_raw !== want.result || a_less !== want.less ||
                    a_equal !== want.equal || a_greater !== want.greater ||
                    div_zero !== want.dz)
                begin
                    errors = errors + 1;
                    $display({"%0t: expected res=%h l=%b e=%b g=%b dz=%b, ",
                              "got res=%h l=%b e=%b g=%b dz=%b"},
                             $time, want.result, want.less, want.equal, want.greater,
                             want.dz, result_raw, a_less, a_equal, a_greater, div_zero);
                end
            end
        end
    end

    initial
    begin
        logic [31:0] edge_vals[8];
        errors = 0;
        cycle_count = 0;
        sender_hold = 0;
        quiet_tail = 0;
        in_xfer = 0;
        send_gap = 0;
        recv_gap = 0;
        recv_hold = 0;
        push = 1'b0;
        pop = 1'b0;
        kind = '0;
        operand_a = '0;
        operand_b = '0;
        edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                      32'h1, 32'h100, 32'hFFFF_FF00, 32'h80};
        for (int k = 0; k <= KIND_INT; k++)
            add_op(4'(k), edge_vals[k % 8], edge_vals[(k * 3 + 1) % 8]);
        add_op(KIND_DIV, 32'h1234, 32'h0);
        add_op(KIND_DIV, 32'h8000_0000, 32'h1);
        add_op(KIND_DIV, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_op(KIND_MUL, 32'h8000_0000, 32'h8000_0000);
        add_op(KIND_MUL, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_op(KIND_MUL, 32'h80, 32'h1);
        add_op(KIND_MUL, 32'hFFFF_FF80, 32'h1);
        add_op(KIND_DIV, 32'h1, 32'h200);
        add_op(KIND_INT, 32'hFFFF_FFFF, 32'h5);
        add_op(4'd9, 32'h5, 32'h7);
        add_op(4'd15, 32'h7, 32'h5);
        add_op(KIND_MIN, 32'h5, 32'h5);
        add_op(KIND_MAX, 32'hFFFF_FFFF, 32'h1);
        for (int i = 0; i < 600; i++)
            add_op(4'($urandom_range(0, 19) == 0 ? $urandom_range(9, 15)
                                                   : $urandom_range(0, 8)),
                   rand_operand(), $urandom_range(0, 30) == 0 ? 32'h0 : rand_operand());
        @(posedge rst_n);
        recv_hold = 300;
        wait (pending_ops.size() == 0);
        sender_hold = 1;
        wait (awaited.size() == 0);
        sender_hold = 0;
        for (int i = 0; i < 520; i++)
            add_op(4'($urandom_range(0, 15)), rand_operand(), rand_operand());
        wait (pending_ops.size() < 100);
        quiet_tail = 1;
        wait (pending_ops.size() == 0 && !push);
        wait (awaited.size() == 0);
        repeat (60) @(posedge clk);
        if (errors == 0 && awaited.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
